### rtl/zcd_pkg.sv
// Shared types and constants for the ZIP central directory parser.
// No dependencies; imported by every module of the block.
package zcd_pkg;

  localparam logic [1:0]  KIND_NAME  = 2'd0;
  localparam logic [1:0]  KIND_ENTRY = 2'd1;
  localparam logic [1:0]  KIND_ERROR = 2'd2;

  localparam logic [31:0] CD_SIGNATURE = 32'h02014b50;
  localparam logic [15:0] ZIP64_ID     = 16'h0001;
  localparam logic [31:0] ZIP64_MARK   = 32'hFFFFFFFF;
  localparam logic [15:0] HDR_LAST     = 16'd45;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_byte;
    logic [15:0] name_length;
    logic [63:0] compressed_size;
    logic [63:0] uncompressed_size;
    logic [63:0] local_header_offset;
    logic [15:0] compression_method;
    logic [31:0] crc_value;
    logic [31:0] entry_index;
    logic        last_entry;
  } res_t;

endpackage

### rtl/zcd_front.sv
// Front end of the ZIP central directory parser: byte classification,
// header capture, Zip64 substitution and result generation. Uses zcd_pkg.
module zcd_front #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata,
  input  logic          byte_vld,
  input  logic [7:0]    byte_in,
  output logic          res_vld,
  output zcd_pkg::res_t res
);
  import zcd_pkg::*;

  typedef enum logic [1:0] {PH_HDR, PH_NAME, PH_EXTRA, PH_CMT} phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [15:0]            pos_r, pos_nxt;
  logic [23:0]            sig_r, sig_nxt;
  logic [15:0]            method_r, method_nxt;
  logic [31:0]            crc_r, crc_nxt;
  logic [31:0]            csz_r, csz_nxt;
  logic [31:0]            usz_r, usz_nxt;
  logic [31:0]            off_r, off_nxt;
  logic [15:0]            nlen_r, nlen_nxt;
  logic [15:0]            xlen_r, xlen_nxt;
  logic [15:0]            clen_r, clen_nxt;
  logic [15:0]            xid_r, xid_nxt;
  logic [15:0]            xsz_r, xsz_nxt;
  logic [4:0]             xcons_r, xcons_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [63:0]            subs_r [3];
  logic [63:0]            subs_nxt [3];
  logic [COUNT_WIDTH-1:0] done_r, done_nxt;
  logic [31:0]            ecount_r;
  logic                   halt_r, halt_nxt;
  logic                   res_vld_nxt;
  res_t                   res_nxt;

  logic [COUNT_WIDTH-1:0] ecm;
  logic [16:0]            pos_inc;
  logic [15:0]            d, diff;
  logic [2:0]             off3, need;
  logic [1:0]             slot;
  logic                   active;

  function automatic logic [1:0] needy(input logic [2:0] f, input logic [1:0] k);
    logic [1:0] cnt;
    logic [1:0] r;
    begin
      cnt = 2'd0;
      r   = 2'd3;
      for (int s = 0; s < 3; s++) begin
        if (f[s]) begin
          if (cnt == k && r == 2'd3) r = 2'(s);
          cnt = cnt + 2'd1;
        end
      end
      return r;
    end
  endfunction

  assign ecm     = COUNT_WIDTH'(ecount_r);
  assign active  = byte_vld && !halt_r && (done_r != ecm);
  assign pos_inc = {1'b0, pos_r} + 17'd1;
  assign d       = pos_r - 16'd4;
  assign diff    = d - {11'd0, xcons_r};
  assign off3    = diff[2:0];
  assign need    = {off_r == ZIP64_MARK, csz_r == ZIP64_MARK, usz_r == ZIP64_MARK};
  assign slot    = needy(need, xcons_r[4:3]);

  always_comb begin
    logic       fin;
    logic [7:0] fin_nb;
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    sig_nxt     = sig_r;
    method_nxt  = method_r;
    crc_nxt     = crc_r;
    csz_nxt     = csz_r;
    usz_nxt     = usz_r;
    off_nxt     = off_r;
    nlen_nxt    = nlen_r;
    xlen_nxt    = xlen_r;
    clen_nxt    = clen_r;
    xid_nxt     = xid_r;
    xsz_nxt     = xsz_r;
    xcons_nxt   = xcons_r;
    acc_nxt     = acc_r;
    subs_nxt    = subs_r;
    done_nxt    = done_r;
    halt_nxt    = halt_r;
    res_vld_nxt = 1'b0;
    res_nxt     = '0;
    fin         = 1'b0;
    fin_nb      = 8'd0;

    res_nxt.name_length        = nlen_r;
    res_nxt.compression_method = method_r;
    res_nxt.crc_value          = crc_r;
    res_nxt.entry_index        = 32'(done_r);
    res_nxt.last_entry         = (done_r + COUNT_WIDTH'(1)) == ecm;

    if (active) begin
      case (phase_r)
        PH_HDR: begin
          pos_nxt = pos_inc[15:0];
          case (pos_r)
            16'd0:  sig_nxt[7:0]      = byte_in;
            16'd1:  sig_nxt[15:8]     = byte_in;
            16'd2:  sig_nxt[23:16]    = byte_in;
            16'd10: method_nxt[7:0]   = byte_in;
            16'd11: method_nxt[15:8]  = byte_in;
            16'd16: crc_nxt[7:0]      = byte_in;
            16'd17: crc_nxt[15:8]     = byte_in;
            16'd18: crc_nxt[23:16]    = byte_in;
            16'd19: crc_nxt[31:24]    = byte_in;
            16'd20: csz_nxt[7:0]      = byte_in;
            16'd21: csz_nxt[15:8]     = byte_in;
            16'd22: csz_nxt[23:16]    = byte_in;
            16'd23: csz_nxt[31:24]    = byte_in;
            16'd24: usz_nxt[7:0]      = byte_in;
            16'd25: usz_nxt[15:8]     = byte_in;
            16'd26: usz_nxt[23:16]    = byte_in;
            16'd27: usz_nxt[31:24]    = byte_in;
            16'd28: nlen_nxt[7:0]     = byte_in;
            16'd29: nlen_nxt[15:8]    = byte_in;
            16'd30: xlen_nxt[7:0]     = byte_in;
            16'd31: xlen_nxt[15:8]    = byte_in;
            16'd32: clen_nxt[7:0]     = byte_in;
            16'd33: clen_nxt[15:8]    = byte_in;
            16'd42: off_nxt[7:0]      = byte_in;
            16'd43: off_nxt[15:8]     = byte_in;
            16'd44: off_nxt[23:16]    = byte_in;
            16'd45: off_nxt[31:24]    = byte_in;
            default: ;
          endcase
          if (pos_r == 16'd3 && {byte_in, sig_r} != CD_SIGNATURE) begin
            halt_nxt           = 1'b1;
            res_vld_nxt        = 1'b1;
            res_nxt            = '0;
            res_nxt.kind       = KIND_ERROR;
            res_nxt.entry_index = 32'(done_r);
          end else if (pos_r == HDR_LAST) begin
            subs_nxt[0] = {32'd0, usz_r};
            subs_nxt[1] = {32'd0, csz_r};
            subs_nxt[2] = {32'd0, byte_in, off_r[23:0]};
            xid_nxt     = 16'd0;
            xsz_nxt     = 16'd0;
            xcons_nxt   = 5'd0;
            acc_nxt     = 64'd0;
            pos_nxt     = 16'd0;
            if (nlen_r != 16'd0)      phase_nxt = PH_NAME;
            else if (xlen_r != 16'd0) phase_nxt = PH_EXTRA;
            else if (clen_r != 16'd0) phase_nxt = PH_CMT;
            else                      fin = 1'b1;
          end
        end
        PH_NAME: begin
          pos_nxt = pos_inc[15:0];
          if (pos_inc >= {1'b0, nlen_r}) begin
            pos_nxt = 16'd0;
            if (xlen_r != 16'd0)      phase_nxt = PH_EXTRA;
            else if (clen_r != 16'd0) phase_nxt = PH_CMT;
            else                      fin = 1'b1;
          end
          fin_nb = byte_in;
          if (!fin) begin
            res_vld_nxt       = 1'b1;
            res_nxt.kind      = KIND_NAME;
            res_nxt.name_byte = byte_in;
          end
        end
        PH_EXTRA: begin
          pos_nxt = pos_inc[15:0];
          if (pos_r == 16'd0)      xid_nxt[7:0]  = byte_in;
          else if (pos_r == 16'd1) xid_nxt[15:8] = byte_in;
          else if (pos_r == 16'd2) xsz_nxt[7:0]  = byte_in;
          else if (pos_r == 16'd3) xsz_nxt[15:8] = byte_in;
          else if (xid_r == ZIP64_ID && d >= {11'd0, xcons_r} && diff < 16'd8) begin
            acc_nxt = ((off3 == 3'd0) ? 64'd0 : acc_r) |
                      ({56'd0, byte_in} << {off3, 3'b000});
            if (off3 == 3'd7 && ({12'd0, xcons_r} + 17'd8) <= {1'b0, xsz_r}
                && slot != 2'd3) begin
              subs_nxt[slot] = acc_nxt;
              xcons_nxt      = xcons_r + 5'd8;
              acc_nxt        = 64'd0;
            end
          end
          if (pos_inc >= {1'b0, xlen_r}) begin
            pos_nxt = 16'd0;
            if (clen_r != 16'd0) phase_nxt = PH_CMT;
            else                 fin = 1'b1;
          end
        end
        default: begin
          pos_nxt = pos_inc[15:0];
          if (pos_inc >= {1'b0, clen_r}) begin
            pos_nxt = 16'd0;
            fin     = 1'b1;
          end
        end
      endcase

      // Close the record: emit the entry and return to header capture.
      if (fin) begin
        res_vld_nxt                 = 1'b1;
        res_nxt.kind                = KIND_ENTRY;
        res_nxt.name_byte           = fin_nb;
        res_nxt.uncompressed_size   = subs_nxt[0];
        res_nxt.compressed_size     = subs_nxt[1];
        res_nxt.local_header_offset = subs_nxt[2];
        done_nxt                    = done_r + COUNT_WIDTH'(1);
        phase_nxt                   = PH_HDR;
        pos_nxt                     = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    method_r <= method_nxt;
    crc_r    <= crc_nxt;
    csz_r    <= csz_nxt;
    usz_r    <= usz_nxt;
    off_r    <= off_nxt;
    nlen_r   <= nlen_nxt;
    xlen_r   <= xlen_nxt;
    clen_r   <= clen_nxt;
    sig_r    <= sig_nxt;
    res      <= res_nxt;
    if (!rst_n || cfg_we) begin
      phase_r <= PH_HDR;
      pos_r   <= '0;
      xid_r   <= '0;
      xsz_r   <= '0;
      xcons_r <= '0;
      acc_r   <= '0;
      subs_r  <= '{default: '0};
      done_r  <= '0;
      halt_r  <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      xid_r   <= xid_nxt;
      xsz_r   <= xsz_nxt;
      xcons_r <= xcons_nxt;
      acc_r   <= acc_nxt;
      subs_r  <= subs_nxt;
      done_r  <= done_nxt;
      halt_r  <= halt_nxt;
      res_vld <= res_vld_nxt;
    end
    if (!rst_n)      ecount_r <= '0;
    else if (cfg_we) ecount_r <= cfg_wdata;
  end

endmodule

### rtl/zcd_queue.sv
// Result queue between parser front end and output port.
// Uses zcd_pkg for the result record type and depth.
module zcd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  zcd_pkg::res_t push_data,
  output logic          space,
  output logic          head_vld,
  output zcd_pkg::res_t head,
  input  logic          pop
);
  import zcd_pkg::*;

  res_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_pop;

  // Leave room for one result still in flight in the front end register.
  assign space    = cnt_r < (QPTR_W + 1)'(QUEUE_DEPTH - 1);
  assign head_vld = cnt_r != '0;
  assign head     = mem[rd_r];
  assign do_pop   = pop && head_vld;

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_data;
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/zip_central_directory_parser.sv
// Top level of the ZIP central directory parser.
// Instantiates zcd_front and zcd_queue; uses zcd_pkg.
//
// Feed the central directory one byte per transaction on the in_ stream; the
// block takes one byte every cycle while its result queue has room. Each
// byte's result passes the front end register into a four-entry result queue
// that drives the out_ stream directly. A stalled consumer blocks input once
// three results wait in the queue; the fourth entry stays free for the result
// still held in the front end register. Results: a name-byte result per file
// name byte not ending its record, an entry result when a record's name,
// extra and comment are consumed (sizes and offset after Zip64 substitution),
// and one error result on a bad record signature, after which input is
// dropped until cfg_entry_count is written again. Writing cfg_entry_count
// restarts parsing; write it only while no transaction is pending. After the
// configured number of entries further bytes are accepted and dropped.
module zip_central_directory_parser #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,         // entry_count
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,          // data_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [295:0] out_tdata,         // name_byte, name_length,
                                          // compressed_size, uncompressed_size,
                                          // local_header_offset,
                                          // compression_method, crc_value,
                                          // entry_index
  output logic [1:0]   out_tuser,         // result_kind
  output logic         out_tlast          // last_entry
);
  import zcd_pkg::*;

  logic res_vld;
  res_t res, head;
  logic space;

  assign in_tready = space;

  zcd_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .byte_vld (in_tvalid && in_tready),
    .byte_in  (in_tdata),
    .res_vld  (res_vld),
    .res      (res)
  );

  zcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_vld),
    .push_data(res),
    .space    (space),
    .head_vld (out_tvalid),
    .head     (head),
    .pop      (out_tready)
  );

  // Pack fields lowest first.
  assign out_tdata = {head.entry_index, head.crc_value, head.compression_method,
                      head.local_header_offset, head.uncompressed_size,
                      head.compressed_size, head.name_length, head.name_byte};
  assign out_tuser = head.kind;
  assign out_tlast = head.last_entry;

endmodule
